// File: src/ins_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_pkg
// Shared types for the insertion sorter: request payloads and cell control.
// ----------------------------------------------------------------------------
package ins_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_result;
    logic                    overflow;
  } out_item_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                    insert;
    logic                    shift;
    logic signed [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

// File: src/ins_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_stream_if
// Valid/ready stream channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface ins_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );
endinterface

// File: src/ins_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_cell
// One slot of the sorted chain: compares the broadcast value against its own
// entry, takes the new value or its left neighbor on insert, and takes its
// right neighbor while the run is shifted out.
// ----------------------------------------------------------------------------
module ins_cell (
  input  logic                            clk_i,
  input  ins_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            occ_i,
  input  logic signed [ins_pkg::DataW-1:0] left_val_i,
  input  logic                            left_gt_i,
  input  logic signed [ins_pkg::DataW-1:0] right_val_i,
  output logic signed [ins_pkg::DataW-1:0] val_o,
  output logic                            gt_o
);
  import ins_pkg::*;

  logic signed [DataW-1:0] val_d, val_q;

  // empty slots act as larger than anything; equal values stay put for stability
  assign gt_o  = !occ_i || (val_q > ctrl_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert) begin
      if (gt_o) begin
        val_d = left_gt_i ? left_val_i : ctrl_i.value;
      end
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: src/insertion_sorter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Stable insertion sorter built from a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// When an element is taken, its value is broadcast to every cell, each cell
// compares it with its own entry in parallel, and the chain opens a slot
// after all equal entries. Once the element marked last has been taken, the
// chain shifts its N held entries out through the output register, one per
// cycle when the sink is ready; no new element is taken while the run
// drains. Elements beyond CAPACITY are dropped and flag overflow on that
// list's results.
// ----------------------------------------------------------------------------
module insertion_sorter_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ins_stream_if.sink          in_ch,
  ins_stream_if.source        out_ch
);
  import ins_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic            state_d, state_q;
  logic [CntW-1:0] count_d, count_q;
  logic [CntW-1:0] rem_d, rem_q;
  logic            dropped_d, dropped_q;
  logic            out_valid_d, out_valid_q;
  out_item_t       out_d, out_q;

  logic            in_fire, do_insert, load;
  cell_ctrl_t      ctrl;
  in_item_t        in_item;

  logic signed [DataW-1:0] cell_val [CAPACITY];
  logic                    cell_gt  [CAPACITY];

  assign in_item   = in_ch.payload;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign do_insert = in_fire && (count_q < CntW'(CAPACITY));
  assign load      = (state_q == ST_DRAIN) && (!out_valid_q || out_ch.ready);

  assign ctrl.insert = do_insert;
  assign ctrl.shift  = load;
  assign ctrl.value  = in_item.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left_val, right_val;
    logic                    left_gt;

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    ins_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (CntW'(i) < count_q),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (do_insert) begin
            count_d = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_item.last_item) begin
            state_d = ST_DRAIN;
            rem_d   = do_insert ? count_q + CntW'(1) : count_q;
          end
        end
      end
      ST_DRAIN: begin
        if (load) begin
          out_valid_d        = 1'b1;
          out_d.sorted_value = cell_val[0];
          out_d.last_result  = (rem_q == CntW'(1));
          out_d.overflow     = dropped_q;
          rem_d              = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d   = ST_IDLE;
            count_d   = '0;
            dropped_d = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (rem_q != '0) && (rem_q <= count_q))
    else $error("drain with no entries left");

  a_last_enters_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_item.last_item) |=> (state_q == ST_DRAIN))
    else $error("last request did not start the drain");

  a_final_result_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && rem_q == CntW'(1)) |=>
      (state_q == ST_IDLE) && (count_q == '0) && !dropped_q && out_q.last_result)
    else $error("final result did not empty the store");

endmodule
